// ===== rtl/hysteresis_dwell_edge_qualifier_macros.svh =====
// ---------------------------------------------------------------------------
// Hysteresis dwell edge qualifier assertion macros
// Shared concurrent assertion forms for the qualifier RTL.
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_DWELL_EDGE_QUALIFIER_MACROS_SVH
`define HYSTERESIS_DWELL_EDGE_QUALIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HDEQ_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HDEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hdeq_pkg.sv =====
// ---------------------------------------------------------------------------
// Hysteresis dwell edge qualifier package
// Types and register indexes shared by the qualifier modules.
// ---------------------------------------------------------------------------
package hdeq_pkg;

   localparam logic [1:0] CSR_ON_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_OFF_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_DWELL_NEEDED  = 2'd2;
   localparam logic [1:0] CSR_DEDUP_WINDOW  = 2'd3;

   localparam logic signed [15:0] ON_THRESHOLD_RESET  = 16'sh4000;
   localparam logic signed [15:0] OFF_THRESHOLD_RESET = -16'sh4000;
   localparam logic [15:0]        DWELL_NEEDED_RESET  = 16'd1;
   localparam logic [31:0]        DEDUP_WINDOW_RESET  = 32'd0;

   localparam logic [15:0] DWELL_MAX = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] on_threshold;
      logic signed [15:0] off_threshold;
      logic [15:0]        dwell_count_needed;
      logic [31:0]        dedup_window;
   } hdeq_cfg_type;

   typedef struct packed {
      logic        committed_level;
      logic        pending_level;
      logic [15:0] dwell_counter;
      logic [31:0] last_emit_time;
      logic        emitted_before;
   } hdeq_state_type;

   typedef struct packed {
      hdeq_state_type next_state;
      logic           emit;
   } hdeq_decision_type;

endpackage

// ===== rtl/hdeq_decide.sv =====
// ---------------------------------------------------------------------------
// Hysteresis dwell edge qualifier decision logic
// Computes the next qualifier state and the emit flag for one sample.
// ---------------------------------------------------------------------------
module hdeq_decide (
   input  logic signed [15:0]          sample_value,
   input  logic [31:0]                 sample_tick,
   input  hdeq_pkg::hdeq_cfg_type      cfg,
   input  hdeq_pkg::hdeq_state_type    cur_state,
   output hdeq_pkg::hdeq_decision_type decision
);
   import hdeq_pkg::*;

   logic        above_on;
   logic        below_off;
   logic [15:0] count_base;
   logic [15:0] count_next;
   logic [31:0] tick_delta;
   logic        suppress;

   assign above_on   = sample_value >= cfg.on_threshold;
   assign below_off  = sample_value <= cfg.off_threshold;
   assign count_base = (above_on != cur_state.pending_level) ? 16'd0
                                                             : cur_state.dwell_counter;
   assign count_next = (count_base == DWELL_MAX) ? count_base : count_base + 16'd1;
   assign tick_delta = sample_tick - cur_state.last_emit_time;
   assign suppress   = (cfg.dedup_window != 32'd0) && cur_state.emitted_before &&
                       (tick_delta < cfg.dedup_window);

   always_comb begin
      decision.next_state = cur_state;
      decision.emit       = 1'b0;
      if (above_on || below_off) begin
         if (above_on == cur_state.committed_level) begin
            decision.next_state.dwell_counter = 16'd0;
         end else begin
            decision.next_state.pending_level = above_on;
            if (count_next < cfg.dwell_count_needed) begin
               decision.next_state.dwell_counter = count_next;
            end else begin
               decision.next_state.committed_level = above_on;
               decision.next_state.dwell_counter   = 16'd0;
               if (!suppress) begin
                  decision.next_state.last_emit_time = sample_tick;
                  decision.next_state.emitted_before = 1'b1;
                  decision.emit                      = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/hysteresis_dwell_edge_qualifier.sv =====
// ---------------------------------------------------------------------------
// Hysteresis dwell edge qualifier
// Hysteresis comparator with dwell debounce and edge deduplication.
// ---------------------------------------------------------------------------
// The block takes one sample item per clock cycle unless stalled and gives at
// most one level-change item per sample from the result register. Throughput is
// set by the qualifier state registers, which are read and updated once per
// cycle by the decision logic; a sample stalls in the input register only when
// it must emit while the result register is still held by the downstream side.
module hysteresis_dwell_edge_qualifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [15:0] sample_value, [47:16] sample_tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [0] new_level, [7:1] zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import hdeq_pkg::*;
   `include "hysteresis_dwell_edge_qualifier_macros.svh"

   hdeq_cfg_type       cfg_ff;
   hdeq_state_type     state_ff;
   hdeq_decision_type  decision;

   logic               s1_valid_ff;
   logic signed [15:0] s1_value_ff;
   logic [31:0]        s1_tick_ff;
   logic               rsp_valid_ff;
   logic               rsp_level_ff;
   logic               out_free;
   logic               s1_advance;
   logic               out_load;

   hdeq_decide u_decide (
      .sample_value (s1_value_ff),
      .sample_tick  (s1_tick_ff),
      .cfg          (cfg_ff),
      .cur_state    (state_ff),
      .decision     (decision)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!decision.emit || out_free);
   assign out_load   = s1_advance && decision.emit;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_level_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold       <= ON_THRESHOLD_RESET;
         cfg_ff.off_threshold      <= OFF_THRESHOLD_RESET;
         cfg_ff.dwell_count_needed <= DWELL_NEEDED_RESET;
         cfg_ff.dedup_window       <= DEDUP_WINDOW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_ON_THRESHOLD:  cfg_ff.on_threshold       <= csr_wdata[15:0];
            CSR_OFF_THRESHOLD: cfg_ff.off_threshold      <= csr_wdata[15:0];
            CSR_DWELL_NEEDED:  cfg_ff.dwell_count_needed <= csr_wdata[15:0];
            CSR_DEDUP_WINDOW:  cfg_ff.dedup_window       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_advance) begin
         state_ff <= decision.next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_value_ff <= req_tdata[15:0];
         s1_tick_ff  <= req_tdata[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_level_ff <= decision.next_state.committed_level;
      end
   end

   `HDEQ_ASSERT_NEXT(a_emit_matches_level, clock, reset, out_load,
      rsp_tdata[0] == state_ff.committed_level, "emitted level differs from committed level")
   `HDEQ_ASSERT_NEXT(a_commit_clears_dwell, clock, reset,
      s1_advance && (decision.next_state.committed_level != state_ff.committed_level),
      state_ff.dwell_counter == 16'd0, "dwell counter not cleared on commit")
   `HDEQ_ASSERT_NEXT(a_stalled_sample_held, clock, reset, s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_tick_ff) && $stable(s1_value_ff),
      "stalled sample lost or changed")
   `HDEQ_ASSERT_NOW(a_emit_needs_room, clock, reset, out_load, out_free,
      "result register overwritten")
   `HDEQ_ASSERT_NEXT(a_emitted_sticks, clock, reset, state_ff.emitted_before,
      state_ff.emitted_before, "emitted flag cleared outside reset")

endmodule
